@@ rtl/core/u8u16_pkg.sv @@
// Package: word types and byte-class constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned UnitW  = 16;
    localparam int unsigned CountW = 16;
    localparam int unsigned PendW  = 2;

    // Lead byte class boundaries and payload masks
    localparam logic [ByteW-1:0] LeadTwoMin   = 8'h80;
    localparam logic [ByteW-1:0] LeadThreeMin = 8'hE0;
    localparam logic [ByteW-1:0] LeadFourMin  = 8'hF0;
    localparam logic [ByteW-1:0] MaskTwo      = 8'h1F;
    localparam logic [ByteW-1:0] MaskThree    = 8'h0F;
    localparam logic [ByteW-1:0] MaskCont     = 8'h3F;
    localparam logic [CountW-1:0] CountMax    = 16'hFFFF;

    // Continuation bytes still expected
    localparam logic [PendW-1:0] PendNone = 2'd0;
    localparam logic [PendW-1:0] PendOne  = 2'd1;
    localparam logic [PendW-1:0] PendTwo  = 2'd2;

    typedef struct packed {
        logic [ByteW-1:0] text_byte;
        logic             final_byte;
    } in_word_t;

    typedef struct packed {
        logic [UnitW-1:0]  code_unit;
        logic [CountW-1:0] unit_count;
        logic              text_end;
    } out_word_t;

endpackage

@@ rtl/core/utf8_to_utf16_bmp_decoder.sv @@
// Top level: byte-serial UTF-8 to UTF-16 (BMP) decoder with a registered result word.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------------
//  s_      | in        | s_valid / s_ready  | text_byte[8], final_byte[1]
//  m_      | out       | m_valid / m_ready  | code_unit[16], unit_count[16], text_end[1]
//
// One byte is taken every cycle while s_ready is high; its result, if any, appears
// in the output register in the next cycle. The decode of a byte is one pass of
// logic from the accumulator registers and the incoming byte into the output register.
// s_ready is high while the output register is empty or being drained this cycle,
// so a stalled result holds the input side whether or not the next byte makes a word.
// Synchronous active-low reset empties the output register and clears the
// accumulator, the pending count and the unit count.
module utf8_to_utf16_bmp_decoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8u16_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8u16_pkg::out_word_t  m_data
);

    // Decoder state
    logic [u8u16_pkg::UnitW-1:0]  partial_value_reg, partial_value_next;
    logic [u8u16_pkg::PendW-1:0]  bytes_pending_reg, bytes_pending_next;
    logic [u8u16_pkg::CountW-1:0] emitted_count_reg, emitted_count_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    u8u16_pkg::out_word_t  m_data_reg, m_data_next;

    logic                          s_accept;
    logic                          emit;
    logic [u8u16_pkg::UnitW-1:0]   emit_unit;
    logic [u8u16_pkg::UnitW-1:0]   acc_value;
    logic [u8u16_pkg::PendW-1:0]   acc_pending;
    logic [u8u16_pkg::CountW-1:0]  count_inc;
    logic [u8u16_pkg::ByteW-1:0]   in_byte;

    // Accept whenever the output register is free or drains in this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign in_byte  = s_data.text_byte;

    // Classify the byte and update the accumulator
    always_comb begin
        emit        = 1'b0;
        emit_unit   = '0;
        acc_value   = partial_value_reg;
        acc_pending = bytes_pending_reg;

        if (bytes_pending_reg != u8u16_pkg::PendNone) begin
            // Continuation: shift in six more bits, no check of the marker bits
            acc_value   = {partial_value_reg[u8u16_pkg::UnitW-7:0], 6'b0}
                        + {8'b0, in_byte & u8u16_pkg::MaskCont};
            acc_pending = bytes_pending_reg - 2'd1;
        end else if (in_byte < u8u16_pkg::LeadTwoMin) begin
            emit      = 1'b1;
            emit_unit = {8'b0, in_byte};
        end else if (in_byte < u8u16_pkg::LeadThreeMin) begin
            // Also catches stray continuation bytes
            acc_value   = {8'b0, in_byte & u8u16_pkg::MaskTwo};
            acc_pending = u8u16_pkg::PendOne;
        end else if (in_byte < u8u16_pkg::LeadFourMin) begin
            acc_value   = {8'b0, in_byte & u8u16_pkg::MaskThree};
            acc_pending = u8u16_pkg::PendTwo;
        end else begin
            // Four-plus-byte leads are not supported: emit zero
            emit      = 1'b1;
            emit_unit = '0;
        end

        if (!emit) begin
            if (acc_pending == u8u16_pkg::PendNone) begin
                emit      = 1'b1;
                emit_unit = acc_value;
            end else if (s_data.final_byte) begin
                // Text ends mid-sequence: pad each missing byte with six zero bits
                emit = 1'b1;
                case (acc_pending)
                    u8u16_pkg::PendOne: emit_unit = {acc_value[u8u16_pkg::UnitW-7:0], 6'b0};
                    u8u16_pkg::PendTwo: emit_unit = {acc_value[u8u16_pkg::UnitW-13:0], 12'b0};
                    default:            emit_unit = '0;
                endcase
            end
        end
    end

    // Saturating unit count
    assign count_inc = (emitted_count_reg == u8u16_pkg::CountMax)
                     ? emitted_count_reg : emitted_count_reg + 16'd1;

    // Next state and next output word
    always_comb begin
        partial_value_next = partial_value_reg;
        bytes_pending_next = bytes_pending_reg;
        emitted_count_next = emitted_count_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;

        if (s_accept) begin
            partial_value_next = acc_value;
            bytes_pending_next = acc_pending;
            if (emit) begin
                m_valid_next           = 1'b1;
                m_data_next.code_unit  = emit_unit;
                m_data_next.unit_count = count_inc;
                m_data_next.text_end   = s_data.final_byte;
                emitted_count_next     = count_inc;
                if (s_data.final_byte) begin
                    // Drop the text's state, ready for the next text
                    partial_value_next = '0;
                    bytes_pending_next = u8u16_pkg::PendNone;
                    emitted_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_value_reg <= '0;
            bytes_pending_reg <= u8u16_pkg::PendNone;
            emitted_count_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            partial_value_reg <= partial_value_next;
            bytes_pending_reg <= bytes_pending_next;
            emitted_count_reg <= emitted_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Pending count never reaches three
    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_pending_reg != 2'd3)
        else $error("bytes_pending reached three");

    // A final byte always yields a result marked as the end of text
    a_final_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_byte |=> m_valid && m_data.text_end)
        else $error("final byte gave no end-of-text word");

    // State is cleared after a final byte
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_byte |=>
            bytes_pending_reg == u8u16_pkg::PendNone && emitted_count_reg == 16'd0)
        else $error("text state not cleared after final byte");

    // Every emitted word counts itself
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.unit_count != 16'd0)
        else $error("result word with zero unit count");
`endif

endmodule

@@ test/utf8_to_utf16_bmp_decoder_test.sv @@
`timescale 1ns / 100ps
// Testbench for the UTF-8 to UTF-16 decoder: directed and random byte streams against a local decode model.
module utf8_to_utf16_bmp_decoder_test;

    localparam int unsigned CycleLimit    = 10_000;
    localparam int unsigned RandomBytes   = 900;
    localparam int unsigned QuietBytes    = 150;
    localparam int unsigned HoldOffCycles = 60;
    localparam int unsigned StallBytes    = 20;
    localparam int unsigned DrainCycles   = 5;
    localparam int unsigned ResetCycles   = 7;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    u8u16_pkg::in_word_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    u8u16_pkg::out_word_t m_data;

    // 12 ns period
    always #6 aclk = ~aclk;

    utf8_to_utf16_bmp_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Local copy of the decoder state: open sequence bits, continuation bytes
    // still owed, and the units emitted so far in the current text.
    logic [u8u16_pkg::UnitW-1:0]  acc_value   = '0;
    logic [u8u16_pkg::PendW-1:0]  acc_pending = u8u16_pkg::PendNone;
    logic [u8u16_pkg::CountW-1:0] text_units  = '0;

    // Result words the decoder still owes, oldest first.
    u8u16_pkg::out_word_t expected_units[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Idle controls: the sender flag belongs to the stimulus process alone;
    // the receiver flags are written with nonblocking assignments so the
    // m_ready process always sees a settled value at the edge.
    bit   sender_calm   = 1'b0;
    logic receiver_calm = 1'b0;
    logic hold_active   = 1'b0;
    event begin_holdoff;

    // Decode one accepted byte and queue the word it produces, if any.
    function automatic void decode_byte(input u8u16_pkg::in_word_t w);
        logic                        emit;
        logic [u8u16_pkg::UnitW-1:0] unit;
        logic [u8u16_pkg::ByteW-1:0] b;
        u8u16_pkg::out_word_t        r;
        b    = w.text_byte;
        emit = 1'b0;
        unit = '0;
        if (acc_pending != u8u16_pkg::PendNone) begin
            // Any byte in this slot is taken as a continuation, unchecked.
            acc_value   = (acc_value << 6) + {8'b0, b & u8u16_pkg::MaskCont};
            acc_pending = acc_pending - 2'd1;
            if (acc_pending == u8u16_pkg::PendNone) begin
                emit = 1'b1;
                unit = acc_value;
            end
        end else if (b < u8u16_pkg::LeadTwoMin) begin
            emit = 1'b1;
            unit = {8'b0, b};
        end else if (b < u8u16_pkg::LeadThreeMin) begin
            acc_value   = {8'b0, b & u8u16_pkg::MaskTwo};
            acc_pending = u8u16_pkg::PendOne;
        end else if (b < u8u16_pkg::LeadFourMin) begin
            acc_value   = {8'b0, b & u8u16_pkg::MaskThree};
            acc_pending = u8u16_pkg::PendTwo;
        end else begin
            // Four-plus-byte leads are outside the plane: emit zero.
            emit = 1'b1;
        end
        // A text that ends inside a sequence pads each missing byte with zeros.
        if (!emit && w.final_byte) begin
            emit = 1'b1;
            unit = acc_value << (6 * acc_pending);
        end
        if (emit) begin
            if (text_units != u8u16_pkg::CountMax) text_units = text_units + 16'd1;
            r.code_unit  = unit;
            r.unit_count = text_units;
            r.text_end   = w.final_byte;
            expected_units.push_back(r);
            if (w.final_byte) begin
                acc_value   = '0;
                acc_pending = u8u16_pkg::PendNone;
                text_units  = '0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [u8u16_pkg::UnitW-1:0] got,
                                   input logic [u8u16_pkg::UnitW-1:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Offer one byte; must be called right after a rising edge. Valid is left
    // high on return so back-to-back words need no second assignment.
    task automatic send_word(input logic [u8u16_pkg::ByteW-1:0] text_byte,
                             input logic is_last);
        u8u16_pkg::in_word_t w;
        w.text_byte  = text_byte;
        w.final_byte = is_last;
        if (!sender_calm && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        // s_ready is sampled before the edge's updates land.
        do @(posedge aclk); while (!s_ready);
        decode_byte(w);
    endtask

    // Compare every word taken from the output with the oldest expectation.
    always @(posedge aclk) begin : check_results
        u8u16_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                report_mismatch("unexpected word, code_unit", m_data.code_unit, '0);
            end else begin
                want = expected_units.pop_front();
                if (m_data.code_unit !== want.code_unit)
                    report_mismatch("code_unit", m_data.code_unit, want.code_unit);
                if (m_data.unit_count !== want.unit_count)
                    report_mismatch("unit_count", m_data.unit_count, want.unit_count);
                if (m_data.text_end !== want.text_end)
                    report_mismatch("text_end", 16'(m_data.text_end), 16'(want.text_end));
            end
        end
    end

    // Receiver: drop ready at random, about one time in ten, unless held or told to stay quiet.
    always @(posedge aclk) begin
        if (hold_active) begin
            m_ready <= 1'b0;
        end else if (receiver_calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial forever begin
        @(begin_holdoff);
        hold_active <= 1'b1;
        repeat (HoldOffCycles) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("utf8_to_utf16_bmp_decoder verification failed");
            $finish;
        end
    end

    // ASCII range ends and the zero byte, which is a character, ending a text.
    task automatic test_plain_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Two-byte forms, including a stray continuation byte taken as a lead.
    task automatic test_two_byte_sequences();
        send_word(8'hC2, 1'b0);
        send_word(8'hA9, 1'b0);
        send_word(8'hDF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h3F, 1'b1);
    endtask

    task automatic test_three_byte_sequences();
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b0);
        send_word(8'hAC, 1'b0);
        send_word(8'hEF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b1);
    endtask

    // Leads of four or more bytes emit zero on their own.
    task automatic test_four_byte_leads();
        send_word(8'hF0, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    // Texts that end in the middle of a sequence: one or two bytes short.
    task automatic test_cut_sequences();
        send_word(8'hC3, 1'b1);
        send_word(8'hE2, 1'b1);
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b1);
    endtask

    // Hold the output while bytes keep coming so the decoder stalls its input.
    task automatic test_output_stall();
        sender_calm = 1'b1;
        -> begin_holdoff;
        for (int unsigned i = 0; i < StallBytes; i++) begin
            send_word(u8u16_pkg::ByteW'($urandom_range(0, 127)), i == StallBytes - 1);
        end
        sender_calm = 1'b0;
    endtask

    // Mostly well-formed characters with random content, some noise bytes,
    // and text ends falling anywhere, including inside sequences.
    task automatic test_random_text();
        int unsigned                 sent;
        int unsigned                 pick;
        int unsigned                 len;
        logic [u8u16_pkg::ByteW-1:0] seq [3];
        sent          = 0;
        sender_calm   = 1'b1;
        receiver_calm <= 1'b1;
        while (sent < RandomBytes) begin
            // Start with a stretch without any idling, then let both sides idle.
            if (sent >= QuietBytes && sender_calm) begin
                sender_calm   = 1'b0;
                receiver_calm <= 1'b0;
            end
            pick   = $urandom_range(0, 99);
            seq[1] = {2'b10, 6'($urandom)};
            seq[2] = {2'b10, 6'($urandom)};
            if (pick < 30) begin
                len    = 1;
                seq[0] = u8u16_pkg::ByteW'($urandom_range(0, 127));
            end else if (pick < 55) begin
                len    = 2;
                seq[0] = u8u16_pkg::ByteW'($urandom_range(8'hC0, 8'hDF));
            end else if (pick < 80) begin
                len    = 3;
                seq[0] = u8u16_pkg::ByteW'($urandom_range(8'hE0, 8'hEF));
            end else begin
                len    = 1;
                seq[0] = u8u16_pkg::ByteW'($urandom);
            end
            for (int unsigned i = 0; i < len; i++) begin
                send_word(seq[i], $urandom_range(0, 99) < 4);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;

        test_plain_bytes();
        test_two_byte_sequences();
        test_three_byte_sequences();
        test_four_byte_leads();
        test_cut_sequences();
        test_output_stall();
        test_random_text();

        // Drain: hold valid low, wait for every owed word, then wait out the DrainCycles margin.
        s_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (error_count == 0) begin
            $display("utf8_to_utf16_bmp_decoder verification clean");
        end else begin
            $display("utf8_to_utf16_bmp_decoder verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/u8u16_pkg.sv
rtl/core/utf8_to_utf16_bmp_decoder.sv
test/utf8_to_utf16_bmp_decoder_test.sv
